// ===== rtl/pla_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pla_pkg
// Shared sizes, types and op codes of the pooled list allocator.
// ----------------------------------------------------------------------------
package pla_pkg;

  // pool geometry
  localparam int POOL_DEPTH = 16;
  localparam int KEY_WIDTH  = 32;
  localparam int AddrW      = $clog2(POOL_DEPTH);
  localparam int IdxW       = $clog2(POOL_DEPTH + 1);
  localparam int CntW       = $clog2(POOL_DEPTH + 1);

  typedef logic [AddrW-1:0]     addr_t;
  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [KEY_WIDTH-1:0] key_t;

  // null link value
  localparam idx_t NIL_IDX = idx_t'(POOL_DEPTH);

  // op codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;
  localparam logic [1:0] OP_NEXT   = 2'd3;

  // write command into the entry store
  typedef struct packed {
    logic  we;
    logic  we_key;
    addr_t addr;
    key_t  key;
    idx_t  link;
  } store_wr_t;

  // an index names a real entry
  function automatic logic idx_ok(idx_t i);
    return i < NIL_IDX;
  endfunction

endpackage : pla_pkg
`default_nettype wire

// ===== rtl/pla_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pla_store
// Entry store: key per entry and successor link per entry, one read port
// and one write port.
// ----------------------------------------------------------------------------
module pla_store (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pla_pkg::store_wr_t wr,
  input  wire pla_pkg::idx_t      rd_idx,
  output pla_pkg::key_t           rd_key,
  output pla_pkg::idx_t           rd_link
);
  import pla_pkg::*;

  key_t keys_r  [POOL_DEPTH];
  idx_t links_r [POOL_DEPTH];

  // key storage, undefined until written
  always_ff @(posedge clk) begin
    if (wr.we && wr.we_key) begin
      keys_r[wr.addr] <= wr.key;
    end
  end

  // link storage, reset chains all entries into the free list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POOL_DEPTH; i++) begin
        links_r[i] <= (i == 0) ? NIL_IDX : idx_t'(i - 1);
      end
    end else if (wr.we) begin
      links_r[wr.addr] <= wr.link;
    end
  end

  // read port, null index reads as empty
  always_comb begin
    if (idx_ok(rd_idx)) begin
      rd_key  = keys_r[rd_idx[AddrW-1:0]];
      rd_link = links_r[rd_idx[AddrW-1:0]];
    end else begin
      rd_key  = '0;
      rd_link = NIL_IDX;
    end
  end

endmodule : pla_store
`default_nettype wire

// ===== rtl/pooled_list_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pooled_list_allocator
// Fixed pool of entries kept as a free list and a used list, newest first.
// Insert, delete by key, and cursor iteration with start and next.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  in      | input     | in_valid, in_ready, in_op, in_key
//  out     | output    | out_valid, out_ready, out_ok, out_key_out, out_used_count
//
// Insert and next pass through S_INS or S_NEXT, then S_RESP to the result
// register; start goes straight to S_RESP. Delete walks the used list one
// entry a cycle through the shared key compare and store read port, then
// S_UNLINK and S_FREE on a match; an absent key ends it at the list end.
// Synchronous active-low reset; the link chain is set in the reset cycle.
// A new item is taken while a result still waits in the output register;
// the sequencer holds before its result stage until that register frees.
// ----------------------------------------------------------------------------
module pooled_list_allocator (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     in_op,
  input  wire pla_pkg::key_t  in_key,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_ok,
  output pla_pkg::key_t       out_key_out,
  output pla_pkg::cnt_t       out_used_count
);
  import pla_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS    = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_UNLINK = 3'd3;
  localparam logic [2:0] S_FREE   = 3'd4;
  localparam logic [2:0] S_NEXT   = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0] state_r, state_nxt;
  key_t       key_r, key_nxt;
  idx_t       used_head_r, used_head_nxt;
  idx_t       free_head_r, free_head_nxt;
  idx_t       cursor_r, cursor_nxt;
  cnt_t       count_r, count_nxt;
  idx_t       cur_r, cur_nxt;
  idx_t       prev_r, prev_nxt;
  idx_t       succ_r, succ_nxt;
  cnt_t       steps_r, steps_nxt;
  logic       res_ok_r, res_ok_nxt;
  key_t       res_key_r, res_key_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_ok_r;
  key_t       out_key_r;
  cnt_t       out_cnt_r;

  store_wr_t  wr;
  idx_t       rd_idx;
  key_t       rd_key;
  idx_t       rd_link;
  logic       key_match;
  logic       out_free;

  pla_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_idx  (rd_idx),
    .rd_key  (rd_key),
    .rd_link (rd_link)
  );

  assign in_ready       = (state_r == S_IDLE) && rst_n;
  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_key_out    = out_key_r;
  assign out_used_count = out_cnt_r;
  assign out_free       = !out_valid_r || out_ready;

  // shared key compare used by the delete walk
  assign key_match = (rd_key == key_r);

  // read port address select
  always_comb begin
    unique case (state_r)
      S_INS:   rd_idx = free_head_r;
      S_NEXT:  rd_idx = cursor_r;
      default: rd_idx = cur_r;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    used_head_nxt = used_head_r;
    free_head_nxt = free_head_r;
    cursor_nxt    = cursor_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    succ_nxt      = succ_r;
    steps_nxt     = steps_r;
    res_ok_nxt    = res_ok_r;
    res_key_nxt   = res_key_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt     = in_key;
          res_ok_nxt  = 1'b0;
          res_key_nxt = '0;
          cur_nxt     = used_head_r;
          prev_nxt    = NIL_IDX;
          steps_nxt   = '0;
          case (in_op)
            OP_INSERT: state_nxt = S_INS;
            OP_DELETE: state_nxt = S_WALK;
            OP_START: begin
              cursor_nxt = used_head_r;
              state_nxt  = S_RESP;
            end
            default:   state_nxt = S_NEXT;
          endcase
        end
      end
      S_INS: begin
        // pop free head, push onto used list
        if (idx_ok(free_head_r)) begin
          wr.we         = 1'b1;
          wr.we_key     = 1'b1;
          wr.addr       = free_head_r[AddrW-1:0];
          wr.key        = key_r;
          wr.link       = used_head_r;
          free_head_nxt = rd_link;
          used_head_nxt = free_head_r;
          count_nxt     = count_r + cnt_t'(1);
          res_ok_nxt    = 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_NEXT: begin
        if (idx_ok(cursor_r)) begin
          res_key_nxt = rd_key;
          cursor_nxt  = rd_link;
          res_ok_nxt  = 1'b1;
        end else begin
          cursor_nxt = NIL_IDX;
        end
        state_nxt = S_RESP;
      end
      S_WALK: begin
        // one entry per cycle
        if (!idx_ok(cur_r) || steps_r == cnt_t'(POOL_DEPTH)) begin
          state_nxt = S_RESP;
        end else if (key_match) begin
          succ_nxt  = rd_link;
          state_nxt = S_UNLINK;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = rd_link;
          steps_nxt = steps_r + cnt_t'(1);
        end
      end
      S_UNLINK: begin
        // bypass the matched entry
        if (idx_ok(prev_r)) begin
          wr.we   = 1'b1;
          wr.addr = prev_r[AddrW-1:0];
          wr.link = succ_r;
        end else begin
          used_head_nxt = succ_r;
        end
        if (cursor_r == cur_r) begin
          cursor_nxt = succ_r;
        end
        state_nxt = S_FREE;
      end
      S_FREE: begin
        // push matched entry onto free list
        wr.we         = 1'b1;
        wr.addr       = cur_r[AddrW-1:0];
        wr.link       = free_head_r;
        free_head_nxt = cur_r;
        if (count_r != '0) begin
          count_nxt = count_r - cnt_t'(1);
        end
        res_ok_nxt = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_head_r <= NIL_IDX;
      free_head_r <= idx_t'(POOL_DEPTH - 1);
      cursor_r    <= NIL_IDX;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_head_r <= used_head_nxt;
      free_head_r <= free_head_nxt;
      cursor_r    <= cursor_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    succ_r    <= succ_nxt;
    steps_r   <= steps_nxt;
    res_ok_r  <= res_ok_nxt;
    res_key_r <= res_key_nxt;
    if (state_r == S_RESP && out_free) begin
      out_ok_r  <= res_ok_r;
      out_key_r <= res_key_r;
      out_cnt_r <= count_r;
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(POOL_DEPTH))
    else $error("used count beyond pool depth");

  a_full_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r == NIL_IDX) |-> (count_r == cnt_t'(POOL_DEPTH)))
    else $error("free list empty while pool not full");

  a_empty_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && used_head_r == NIL_IDX) |-> (count_r == '0))
    else $error("used list empty with nonzero count");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("sequencer idle right after input transfer");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (steps_r <= cnt_t'(POOL_DEPTH)))
    else $error("delete walk ran past pool depth");

endmodule : pooled_list_allocator
`default_nettype wire
